### hdl/mrpm_pkg.sv
// Package for the microphone RMS and peak level meter.
// Holds the item structs, the queue entry, the state enums and fixed widths.
// No dependencies.
package mrpm_pkg;

    // fixed field widths
    localparam int RAW_W    = 32;
    localparam int SMP_W    = 16;
    localparam int MAG_W    = 16;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 40;
    localparam int RMS_W    = 16;
    localparam int FCNT_W   = 10;
    localparam int SHIFT    = 12;
    localparam int FCNT_MAX = 1023;

    // iterative divide and root unit
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = RMS_W;
    localparam int RAD_W      = 2 * RMS_W;
    localparam int STEP_W     = 6;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_word;
        logic                    last_in_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] converted_sample;
        logic                    frame_done;
        logic [RMS_W-1:0]        rms_level;
        logic [MAG_W-1:0]        peak_level;
        logic [FCNT_W-1:0]       frame_samples;
    } out_item_t;

    // one converted sample waiting for the back end
    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic [MAG_W-1:0]        mag;
        logic                    last;
    } q_entry_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ACC,
        B_CALC,
        B_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT
    } root_state_t;

endpackage

### hdl/mrpm_front.sv
// Front end: converts the raw word to a saturated sample and its magnitude,
// and holds it in a two-entry queue for the back end. Depends on mrpm_pkg.
module mrpm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  mrpm_pkg::in_item_t sample_item,
    output logic              head_valid,
    output mrpm_pkg::q_entry_t head,
    input  logic              pop
);
    import mrpm_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    logic signed [RAW_W-SHIFT-1:0] shifted;
    logic signed [SMP_W-1:0]       sample;
    logic signed [SMP_W:0]         neg_wide;
    logic [MAG_W-1:0]              mag;
    q_entry_t                      entry;
    logic                          push;

    q_entry_t           mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // arithmetic shift by dropping the low bits, then saturate to 16 bits
    always_comb
    begin
        shifted = sample_item.raw_word[RAW_W-1:SHIFT];
        if (shifted > $signed(20'sd32767))
            sample = 16'sh7FFF;
        else if (shifted < -$signed(20'sd32768))
            sample = 16'sh8000;
        else
            sample = shifted[SMP_W-1:0];
        // most negative sample gives 32768, which fits unsigned
        neg_wide = -{sample[SMP_W-1], sample};
        mag      = sample[SMP_W-1] ? neg_wide[MAG_W-1:0] : sample;
        entry.sample = sample;
        entry.mag    = mag;
        entry.last   = sample_item.last_in_frame;
    end

    // queue control
    assign sample_stall = (cnt_reg == CNT_W'(Q_DEPTH));
    assign push         = sample_valid && !sample_stall;
    assign head_valid   = (cnt_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry;
    end

endmodule

### hdl/mrpm_root.sv
// Iterative unit: restoring divide of the frame sum by the count, one
// quotient bit a cycle, then a digit-by-digit square root, two bits a cycle.
// Depends on mrpm_pkg.
module mrpm_root #(
    parameter int CW = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mrpm_pkg::SUM_W-1:0]  dividend,
    input  logic [CW-1:0]               divisor,
    output logic                        busy,
    output logic [mrpm_pkg::RMS_W-1:0]  root
);
    import mrpm_pkg::*;

    root_state_t         state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    q_reg;
    logic [CW-1:0]       rem_reg;
    logic [CW-1:0]       div_reg;
    logic [RMS_W+1:0]    srem_reg;
    logic [RMS_W-1:0]    root_reg;

    logic                div_en, sqrt_en, last_div, last_sqrt;
    logic [CW:0]         d_shift, d_diff;
    logic                d_bit;
    logic [RMS_W+3:0]    s_shift, s_trial, s_diff;
    logic                s_bit;

    assign last_div  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign last_sqrt = (step_reg == STEP_W'(SQRT_STEPS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            R_IDLE:  if (start) state_next = R_DIV;
            R_DIV:   if (last_div) state_next = R_SQRT;
            R_SQRT:  if (last_sqrt) state_next = R_IDLE;
            default: state_next = R_IDLE;
        endcase
    end

    // outputs and step enables
    always_comb
    begin
        div_en  = 1'b0;
        sqrt_en = 1'b0;
        busy    = 1'b1;
        case (state_reg)
            R_IDLE:  busy = 1'b0;
            R_DIV:   div_en = 1'b1;
            R_SQRT:  sqrt_en = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    assign root = root_reg;

    // one restoring divide step
    always_comb
    begin
        d_shift = {rem_reg, q_reg[SUM_W-1]};
        d_diff  = d_shift - {1'b0, div_reg};
        d_bit   = (d_shift >= {1'b0, div_reg});
    end

    // one root step on the top two bits of the radicand
    always_comb
    begin
        s_shift = {srem_reg, q_reg[RAD_W-1:RAD_W-2]};
        s_trial = {2'b00, root_reg, 2'b01};
        s_diff  = s_shift - s_trial;
        s_bit   = (s_shift >= s_trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start || (div_en && last_div) || (sqrt_en && last_sqrt))
                step_reg <= '0;
            else if (div_en || sqrt_en)
                step_reg <= step_reg + 1'b1;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            q_reg   <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (div_en)
        begin
            q_reg   <= {q_reg[SUM_W-2:0], d_bit};
            rem_reg <= d_bit ? d_diff[CW-1:0] : d_shift[CW-1:0];
            if (last_div)
            begin
                srem_reg <= '0;
                root_reg <= '0;
            end
        end
        else if (sqrt_en)
        begin
            q_reg    <= {q_reg[SUM_W-3:0], 2'b00};
            srem_reg <= s_bit ? s_diff[RMS_W+1:0] : s_shift[RMS_W+1:0];
            root_reg <= {root_reg[RMS_W-2:0], s_bit};
        end
    end

endmodule

### hdl/mrpm_back.sv
// Back end: squares each sample, accumulates sum, peak and count, closes
// frames through the divide and root unit and drives the result register.
// Depends on mrpm_pkg and mrpm_root.
module mrpm_back #(
    parameter int MAX_FRAME = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mrpm_pkg::q_entry_t  head,
    output logic                pop,
    output logic                level_valid,
    input  logic                level_stall,
    output mrpm_pkg::out_item_t level_item
);
    import mrpm_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);

    back_state_t             state_reg, state_next;
    logic signed [SMP_W-1:0] cur_sample_reg;
    logic [MAG_W-1:0]        cur_mag_reg;
    logic                    cur_last_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic                    close_reg;

    logic [SUM_W-1:0]        sum_reg, sum_sat;
    logic [MAG_W-1:0]        peak_reg, peak_new;
    logic [CW-1:0]           cnt_reg, cnt_inc;
    logic [MAG_W-1:0]        fin_peak_reg;
    logic [CW-1:0]           fin_cnt_reg;
    logic [SUM_W:0]          sum_wide;
    logic                    close_now;

    logic                    out_valid_reg;
    out_item_t               out_reg, out_next;
    logic                    out_free, acc_en, root_start, out_load;
    logic                    root_busy;
    logic [RMS_W-1:0]        root_val;
    logic [FCNT_W-1:0]       fcnt_sat;

    mrpm_root #(.CW(CW)) u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .dividend (sum_sat),
        .divisor  (cnt_inc),
        .busy     (root_busy),
        .root     (root_val)
    );

    assign out_free = !out_valid_reg || !level_stall;

    // accumulate with saturation of the sum
    always_comb
    begin
        sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
        sum_sat   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        peak_new  = (cur_mag_reg > peak_reg) ? cur_mag_reg : peak_reg;
        cnt_inc   = cnt_reg + 1'b1;
        close_now = cur_last_reg || (cnt_inc >= MAX_CNT);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (head_valid) state_next = B_ACC;
            B_ACC:   state_next = close_now ? B_CALC : B_OUT;
            B_CALC:  if (!root_busy) state_next = B_OUT;
            B_OUT:
            begin
                if (out_free)
                    state_next = head_valid ? B_ACC : B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        pop        = 1'b0;
        acc_en     = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            B_IDLE:  pop = head_valid;
            B_ACC:
            begin
                acc_en     = 1'b1;
                root_start = close_now;
            end
            B_CALC:  ;
            B_OUT:
            begin
                out_load = out_free;
                pop      = out_free && head_valid;
            end
            default: ;
        endcase
    end

    // result item
    always_comb
    begin
        fcnt_sat = (32'(fin_cnt_reg) > FCNT_MAX) ? FCNT_W'(FCNT_MAX) : FCNT_W'(fin_cnt_reg);
        out_next.converted_sample = cur_sample_reg;
        out_next.frame_done       = close_reg;
        out_next.rms_level        = close_reg ? root_val : '0;
        out_next.peak_level       = close_reg ? fin_peak_reg : '0;
        out_next.frame_samples    = close_reg ? fcnt_sat : '0;
    end

    assign level_valid = out_valid_reg;
    assign level_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!level_stall)
                out_valid_reg <= 1'b0;
            if (acc_en)
            begin
                if (close_now)
                begin
                    sum_reg  <= '0;
                    peak_reg <= '0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    sum_reg  <= sum_sat;
                    peak_reg <= peak_new;
                    cnt_reg  <= cnt_inc;
                end
            end
        end
    end

    // item payload, no reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_sample_reg <= head.sample;
            cur_mag_reg    <= head.mag;
            cur_last_reg   <= head.last;
            sq_reg         <= SQ_W'(head.mag) * SQ_W'(head.mag);
        end
        if (acc_en)
        begin
            close_reg    <= close_now;
            fin_peak_reg <= peak_new;
            fin_cnt_reg  <= cnt_inc;
        end
        if (out_load)
            out_reg <= out_next;
    end

endmodule

### hdl/mic_rms_peak_level_meter_unit.sv
// Top level of the microphone RMS and peak level meter.
// Joins the converting front end and the accumulating back end.
// Depends on mrpm_pkg, mrpm_front, mrpm_back (and mrpm_root below it).
//
//  channel   dir  handshake                   payload
//  sample    in   sample_valid/sample_stall   in_item_t  (raw_word, last_in_frame)
//  level     out  level_valid/level_stall     out_item_t (sample, done, rms, peak, count)
//
// An item that does not close a frame passes the back-end states for
// accumulate, then result load with fetch of the next queued item.
// An item that closes a frame adds the divide steps, one per sum bit, and
// the root steps, one per result bit, in the shared divide/root unit.
// Reset clears the queue, the accumulators and all control state.
// A stalled result holds the back end; the two-entry queue then fills
// and sample_stall rises.
module mic_rms_peak_level_meter_unit #(
    parameter int MAX_FRAME = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  mrpm_pkg::in_item_t  sample_item,
    output logic                level_valid,
    input  logic                level_stall,
    output mrpm_pkg::out_item_t level_item
);
    import mrpm_pkg::*;

    logic     head_valid;
    q_entry_t head;
    logic     pop;

    mrpm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    mrpm_back #(.MAX_FRAME(MAX_FRAME)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .level_valid (level_valid),
        .level_stall (level_stall),
        .level_item  (level_item)
    );

    // the back end only takes from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

    // a full queue always has a head for the back end
    assert property (@(posedge clk) disable iff (!rst_n) sample_stall |-> head_valid)
        else $error("queue stalls while empty");

    // open frame reports no statistics
    assert property (@(posedge clk) disable iff (!rst_n)
        (level_valid && !level_item.frame_done) |->
        (level_item.rms_level == '0 && level_item.peak_level == '0 &&
         level_item.frame_samples == '0))
        else $error("statistics on open frame");

    // closed frame: non-empty and rms never above peak
    assert property (@(posedge clk) disable iff (!rst_n)
        (level_valid && level_item.frame_done) |->
        (level_item.frame_samples != '0 && level_item.rms_level <= level_item.peak_level))
        else $error("bad frame statistics");

endmodule
